// ===== rtl/ppe_pkg.sv =====
package ppe_pkg;

    // Pool geometry.
    localparam int POOL_SIZE = 64;
    localparam int IDX_W     = $clog2(POOL_SIZE);
    localparam int CNT_W     = $clog2(POOL_SIZE + 1);

    // Item modes.
    localparam logic [1:0] MODE_EMIT   = 2'd0;
    localparam logic [1:0] MODE_TICK   = 2'd1;
    localparam logic [1:0] MODE_RENDER = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SPREAD_X = 2'd0;
    localparam logic [1:0] CFG_SPREAD_Y = 2'd1;
    localparam logic [1:0] CFG_SPREAD_Z = 2'd2;

    // Saturation bounds for signed 32-bit results.
    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    // One pool slot as held in the slot memory.
    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [31:0]      total;
        logic [31:0]      life;
        logic [3:0][7:0]  col_begin;
        logic [3:0][7:0]  col_end;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EMIT_MUL,
        ST_EMIT_ADD,
        ST_EMIT_WRITE,
        ST_SCAN,
        ST_READ,
        ST_TICK_MUL,
        ST_TICK_ADD,
        ST_TICK_WRITE,
        ST_DIV,
        ST_MIX_MUL,
        ST_MIX_ADD,
        ST_OUT,
        ST_EMPTY
    } state_t;

    // Clamp a wide signed value to signed 32 bits.
    function automatic logic [31:0] sat32(input logic signed [65:0] x);
        logic [31:0] r;
        if (x > SAT_MAX)
        begin
            r = 32'h7FFF_FFFF;
        end
        else if (x < SAT_MIN)
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/ppe_ram.sv =====
module ppe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/ppe_mul.sv =====
module ppe_mul
    import ppe_pkg::*;
(
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] p
);

    // Shared signed multiplier with a registered product.
    always_ff @(posedge clk)
    begin
        p <= a * b;
    end

endmodule

// ===== rtl/particle_pool_engine.sv =====
// Each axis or colour step is a multiply on one shared 33x33 multiplier, then an add.
// Emit jitters the speed per axis and writes the slot. Tick moves each live slot per axis.
// Render gets each live slot's fraction from the 16-step shift-subtract divider (not at
// full life), mixes each colour channel and sends a beat that waits out any stall.
// The block takes one item at a time; in_stall stays high while it works. Reset (rst_n
// low, asynchronous) kills every slot, clears the spreads and sets the pointer to the top.
module particle_pool_engine
    import ppe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [31:0] start_x,
    input  logic [31:0] start_y,
    input  logic [31:0] start_z,
    input  logic [31:0] speed_x,
    input  logic [31:0] speed_y,
    input  logic [31:0] speed_z,
    input  logic [31:0] time_value,
    input  logic [31:0] hue_begin,
    input  logic [31:0] hue_end,
    input  logic [47:0] jitter,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] out_x,
    output logic [31:0] out_y,
    output logic [31:0] out_z,
    output logic [31:0] out_colour,
    output logic [15:0] life_fraction,
    output logic        last,
    output logic        none_live,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     ptr_reg;
    logic [1:0]           ax_reg;
    logic [3:0]           div_cnt_reg;
    logic [POOL_SIZE-1:0] live_reg;
    logic                 out_valid_reg;
    logic [2:0][31:0]     spread_reg;

    logic [1:0]       mode_reg;
    logic [2:0][31:0] start_reg;
    logic [2:0][31:0] speed_reg;
    logic [31:0]      time_reg;
    logic [31:0]      hue_b_reg;
    logic [31:0]      hue_e_reg;
    logic [2:0][15:0] jitter_reg;
    slot_t            work_reg;
    logic [31:0]      rem_reg;
    logic [15:0]      frac_reg;
    logic [31:0]      colour_reg;

    logic [31:0] out_x_reg, out_y_reg, out_z_reg, out_colour_reg;
    logic [15:0] frac_out_reg;
    logic        last_reg, none_reg;

    logic               in_accept;
    logic               out_free;
    logic [IDX_W-1:0]   slot_idx;
    logic               scan_done;
    logic               above_none;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [65:0] prod_fl;
    logic [31:0]        vel_new, pos_new;
    logic [65:0]        mix_sum;
    logic [32:0]        rem2;
    logic               rem_ge;
    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    slot_t              ram_wr_data;
    slot_t              ram_rd_data;
    slot_t              emit_slot;
    slot_t              tick_slot;
    logic [POOL_SIZE-1:0] above_bits;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign slot_idx  = idx_reg[IDX_W-1:0];
    assign scan_done = (idx_reg == CNT_W'(POOL_SIZE));

    // Live slots above the current one decide the end-of-run flag.
    assign above_bits = (live_reg >> slot_idx) >> 1;
    assign above_none = ~|above_bits;

    // Shared multiplier and the views of its product.
    ppe_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign prod_fl = mul_p >>> 16;
    assign vel_new = sat32($signed({{34{speed_reg[ax_reg][31]}}, speed_reg[ax_reg]}) + prod_fl);
    assign pos_new = sat32($signed({{34{work_reg.pos[ax_reg][31]}}, work_reg.pos[ax_reg]})
                           + prod_fl);
    assign mix_sum = {42'd0, work_reg.col_end[ax_reg], 16'd0} + mul_p;

    // Divider step on the remainder.
    assign rem2   = {rem_reg, 1'b0};
    assign rem_ge = (rem2 >= {1'b0, work_reg.total});

    // Slot contents for the two kinds of write.
    always_comb
    begin
        emit_slot           = work_reg;
        emit_slot.pos       = start_reg;
        emit_slot.total     = time_reg;
        emit_slot.life      = time_reg;
        emit_slot.col_begin = hue_b_reg;
        emit_slot.col_end   = hue_e_reg;
        tick_slot           = work_reg;
        tick_slot.life      = work_reg.life - time_reg;
    end

    ppe_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (POOL_SIZE)
    ) u_slots (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (slot_idx),
        .rd_data (ram_rd_data)
    );

    // Sequencer: next state, multiplier operands and memory write.
    always_comb
    begin
        state_next  = state_reg;
        mul_a       = '0;
        mul_b       = '0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = slot_idx;
        ram_wr_data = tick_slot;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (mode == MODE_EMIT)
                    begin
                        state_next = ST_EMIT_MUL;
                    end
                    else if (mode == MODE_TICK)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (mode == MODE_RENDER)
                    begin
                        state_next = (live_reg == '0) ? ST_EMPTY : ST_SCAN;
                    end
                end
            end
            ST_EMIT_MUL:
            begin
                mul_a      = $signed({1'b0, spread_reg[ax_reg]});
                mul_b      = $signed({{18{~jitter_reg[ax_reg][15]}},
                                      jitter_reg[ax_reg][14:0]});
                state_next = ST_EMIT_ADD;
            end
            ST_EMIT_ADD:
            begin
                state_next = (ax_reg == 2'd2) ? ST_EMIT_WRITE : ST_EMIT_MUL;
            end
            ST_EMIT_WRITE:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = ptr_reg;
                ram_wr_data = emit_slot;
                state_next  = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_IDLE;
                end
                else if (live_reg[slot_idx])
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = (mode_reg == MODE_TICK) ? ST_TICK_MUL :
                             (ram_rd_data.life >= ram_rd_data.total) ? ST_MIX_MUL : ST_DIV;
            end
            ST_TICK_MUL:
            begin
                mul_a      = $signed({work_reg.vel[ax_reg][31], work_reg.vel[ax_reg]});
                mul_b      = $signed({1'b0, time_reg});
                state_next = ST_TICK_ADD;
            end
            ST_TICK_ADD:
            begin
                state_next = (ax_reg == 2'd2) ? ST_TICK_WRITE : ST_TICK_MUL;
            end
            ST_TICK_WRITE:
            begin
                ram_wr_en  = 1'b1;
                state_next = ST_SCAN;
            end
            ST_DIV:
            begin
                state_next = (div_cnt_reg == 4'd15) ? ST_MIX_MUL : ST_DIV;
            end
            ST_MIX_MUL:
            begin
                mul_a      = $signed(33'({1'b0, work_reg.col_begin[ax_reg]})
                                     - 33'({1'b0, work_reg.col_end[ax_reg]}));
                mul_b      = $signed({17'd0, frac_reg});
                state_next = ST_MIX_ADD;
            end
            ST_MIX_ADD:
            begin
                state_next = (ax_reg == 2'd3) ? ST_OUT : ST_MIX_MUL;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers: counters, pointer, live bits, spreads, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            ptr_reg       <= IDX_W'(POOL_SIZE - 1);
            ax_reg        <= '0;
            div_cnt_reg   <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
            spread_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SPREAD_X)
                begin
                    spread_reg[0] <= cfg_data;
                end
                else if (cfg_index == CFG_SPREAD_Y)
                begin
                    spread_reg[1] <= cfg_data;
                end
                else if (cfg_index == CFG_SPREAD_Z)
                begin
                    spread_reg[2] <= cfg_data;
                end
            end

            // A new beat loads when the output is free; a taken beat clears valid.
            if ((state_reg == ST_OUT || state_reg == ST_EMPTY) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    idx_reg <= '0;
                    ax_reg  <= '0;
                end
                ST_EMIT_ADD, ST_TICK_ADD, ST_MIX_ADD:
                begin
                    ax_reg <= ax_reg + 2'd1;
                end
                ST_EMIT_WRITE:
                begin
                    live_reg[ptr_reg] <= (time_reg != 32'd0);
                    ptr_reg <= (ptr_reg == '0) ? IDX_W'(POOL_SIZE - 1) : ptr_reg - 1'b1;
                end
                ST_SCAN:
                begin
                    ax_reg <= '0;
                    if (!scan_done && !live_reg[slot_idx])
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_READ:
                begin
                    ax_reg      <= '0;
                    div_cnt_reg <= '0;
                end
                ST_TICK_WRITE:
                begin
                    live_reg[slot_idx] <= (work_reg.life > time_reg);
                    idx_reg <= idx_reg + 1'b1;
                end
                ST_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 4'd1;
                    ax_reg      <= '0;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers: input latch, working slot, divider and results.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg   <= mode;
            start_reg  <= {start_z, start_y, start_x};
            speed_reg  <= {speed_z, speed_y, speed_x};
            time_reg   <= time_value;
            hue_b_reg  <= hue_begin;
            hue_e_reg  <= hue_end;
            jitter_reg <= jitter;
        end

        case (state_reg)
            ST_EMIT_ADD:
            begin
                work_reg.vel[ax_reg] <= vel_new;
            end
            ST_READ:
            begin
                work_reg <= ram_rd_data;
                rem_reg  <= ram_rd_data.life;
                frac_reg <= (ram_rd_data.life >= ram_rd_data.total) ? 16'hFFFF : 16'd0;
            end
            ST_TICK_ADD:
            begin
                work_reg.pos[ax_reg] <= pos_new;
            end
            ST_DIV:
            begin
                rem_reg  <= rem_ge ? 32'(rem2 - {1'b0, work_reg.total}) : rem2[31:0];
                frac_reg <= {frac_reg[14:0], rem_ge};
            end
            ST_MIX_ADD:
            begin
                colour_reg[ax_reg * 8 +: 8] <= mix_sum[23:16];
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_x_reg      <= work_reg.pos[0];
                    out_y_reg      <= work_reg.pos[1];
                    out_z_reg      <= work_reg.pos[2];
                    out_colour_reg <= colour_reg;
                    frac_out_reg   <= frac_reg;
                    last_reg       <= above_none;
                    none_reg       <= 1'b0;
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_x_reg      <= '0;
                    out_y_reg      <= '0;
                    out_z_reg      <= '0;
                    out_colour_reg <= '0;
                    frac_out_reg   <= '0;
                    last_reg       <= 1'b1;
                    none_reg       <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign out_x         = out_x_reg;
    assign out_y         = out_y_reg;
    assign out_z         = out_z_reg;
    assign out_colour    = out_colour_reg;
    assign life_fraction = frac_out_reg;
    assign last          = last_reg;
    assign none_live     = none_reg;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ppe_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 1000;
    localparam int HOLD_CYCLES    = 3000;
    localparam int RANDOM_ITEMS   = 432;

    // One input item as offered to the block.
    typedef struct {
        logic [1:0]  mode;
        logic [31:0] start [3];
        logic [31:0] speed [3];
        logic [31:0] time_value;
        logic [31:0] hue_begin;
        logic [31:0] hue_end;
        logic [47:0] jitter;
    } item_t;

    // One rendered particle as the block should report it.
    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] colour;
        logic [15:0] frac;
        logic        last;
        logic        none_live;
    } particle_beat_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  mode;
    logic [31:0] start_x, start_y, start_z;
    logic [31:0] speed_x, speed_y, speed_z;
    logic [31:0] time_value;
    logic [31:0] hue_begin, hue_end;
    logic [47:0] jitter;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] out_x, out_y, out_z, out_colour;
    logic [15:0] life_fraction;
    logic        last;
    logic        none_live;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    // Shadow copy of the pool.
    logic signed [31:0] pool_pos [POOL_SIZE][3];
    logic signed [31:0] pool_vel [POOL_SIZE][3];
    logic [31:0]        pool_total [POOL_SIZE];
    longint             pool_left [POOL_SIZE];
    logic [31:0]        pool_begin [POOL_SIZE];
    logic [31:0]        pool_end [POOL_SIZE];
    int                 emit_slot;
    logic [31:0]        spread [3];

    particle_beat_t pending_beats[$];
    int             fail_count;
    int             in_gap_pct;
    int             out_stall_pct;
    bit             hold_request;
    int             hold_left;
    int             quiet_cycles;

    particle_pool_engine DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .start_x(start_x),
        .start_y(start_y),
        .start_z(start_z),
        .speed_x(speed_x),
        .speed_y(speed_y),
        .speed_z(speed_z),
        .time_value(time_value),
        .hue_begin(hue_begin),
        .hue_end(hue_end),
        .jitter(jitter),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_x(out_x),
        .out_y(out_y),
        .out_z(out_z),
        .out_colour(out_colour),
        .life_fraction(life_fraction),
        .last(last),
        .none_live(none_live),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Clock generation.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Clamp to the signed 32-bit range.
    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'h7FFF_FFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Blend end colour toward begin colour by the life fraction.
    function automatic logic [31:0] blend_colour(input logic [31:0] endc,
                                                 input logic [31:0] beginc,
                                                 input logic [15:0] t);
        logic [31:0] res;
        longint      c;
        res = '0;
        for (int ch = 0; ch < 4; ch++)
        begin
            c = (longint'(endc[8*ch +: 8]) * (65536 - longint'(t))
                 + longint'(beginc[8*ch +: 8]) * longint'(t)) >>> 16;
            res[8*ch +: 8] = c[7:0];
        end
        return res;
    endfunction

    // Update the shadow pool for one accepted item and queue its results.
    task automatic predict_pool(input item_t it);
        longint         f;
        longint         d;
        longint         q;
        logic [15:0]    t;
        int             found;
        particle_beat_t b;
        case (it.mode)
            MODE_EMIT:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    f = longint'(it.jitter[16*a +: 16]) - 32768;
                    d = (longint'(spread[a]) * f) >>> 16;
                    pool_pos[emit_slot][a] = it.start[a];
                    pool_vel[emit_slot][a] =
                        clamp32(longint'(signed'(it.speed[a])) + d);
                end
                pool_total[emit_slot] = it.time_value;
                pool_left[emit_slot]  = longint'(it.time_value);
                pool_begin[emit_slot] = it.hue_begin;
                pool_end[emit_slot]   = it.hue_end;
                emit_slot = (emit_slot == 0) ? POOL_SIZE - 1 : emit_slot - 1;
            end
            MODE_TICK:
            begin
                for (int i = 0; i < POOL_SIZE; i++)
                begin
                    if (pool_left[i] > 0)
                    begin
                        pool_left[i] -= longint'(it.time_value);
                        for (int a = 0; a < 3; a++)
                        begin
                            d = (longint'(pool_vel[i][a]) * longint'(it.time_value)) >>> 16;
                            pool_pos[i][a] = clamp32(longint'(pool_pos[i][a]) + d);
                        end
                    end
                end
            end
            MODE_RENDER:
            begin
                found = 0;
                for (int i = 0; i < POOL_SIZE; i++)
                begin
                    if (pool_left[i] > 0)
                    begin
                        if (pool_total[i] == 0)
                        begin
                            t = 16'hFFFF;
                        end
                        else
                        begin
                            q = (pool_left[i] << 16) / longint'(pool_total[i]);
                            t = (q > 65535) ? 16'hFFFF : q[15:0];
                        end
                        b.x         = pool_pos[i][0];
                        b.y         = pool_pos[i][1];
                        b.z         = pool_pos[i][2];
                        b.colour    = blend_colour(pool_end[i], pool_begin[i], t);
                        b.frac      = t;
                        b.last      = 1'b0;
                        b.none_live = 1'b0;
                        pending_beats.insert(pending_beats.size(), b);
                        found++;
                    end
                end
                if (found == 0)
                begin
                    b = '{default: '0};
                    b.last      = 1'b1;
                    b.none_live = 1'b1;
                    pending_beats.insert(pending_beats.size(), b);
                end
                else
                begin
                    pending_beats[$].last = 1'b1;
                end
            end
            default:
            begin
                // An unused mode leaves the pool alone.
            end
        endcase
    endtask

    // Offer one item, wait for its acceptance, then predict it.
    task automatic send_item(input item_t it);
        if ($urandom_range(99) < in_gap_pct)
        begin
            repeat ($urandom_range(1, 6))
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        mode       <= it.mode;
        start_x    <= it.start[0];
        start_y    <= it.start[1];
        start_z    <= it.start[2];
        speed_x    <= it.speed[0];
        speed_y    <= it.speed[1];
        speed_z    <= it.speed[2];
        time_value <= it.time_value;
        hue_begin  <= it.hue_begin;
        hue_end    <= it.hue_end;
        jitter     <= it.jitter;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        predict_pool(it);
    endtask

    // Stop offering, then wait until every result is in and the block settles.
    task automatic drain_pool();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one spread register over the configuration channel.
    task automatic write_spread(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        spread[idx] = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all_spreads(input logic [31:0] vx, input logic [31:0] vy,
                                     input logic [31:0] vz);
        write_spread(CFG_SPREAD_X, vx);
        write_spread(CFG_SPREAD_Y, vy);
        write_spread(CFG_SPREAD_Z, vz);
    endtask

    // A 32-bit value that favors extremes and small magnitudes.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic item_t make_item(input logic [1:0] m);
        item_t it;
        it.mode = m;
        for (int a = 0; a < 3; a++)
        begin
            it.start[a] = pick_word();
            it.speed[a] = pick_word();
        end
        it.hue_begin = $urandom;
        it.hue_end   = $urandom;
        it.jitter    = {16'($urandom), 32'($urandom)};
        it.time_value = $urandom;
        return it;
    endfunction

    // Mostly emits with lifetimes that survive several ticks.
    function automatic item_t random_item();
        item_t it;
        int    r;
        r = $urandom_range(99);
        if (r < 55)
        begin
            it = make_item(MODE_EMIT);
            case ($urandom_range(9))
                0: it.time_value = 32'h0;
                1: it.time_value = 32'hFFFF_FFFF;
                default: it.time_value = $urandom_range(1, 40) << 16 | $urandom_range(0, 65535);
            endcase
        end
        else if (r < 80)
        begin
            it = make_item(MODE_TICK);
            case ($urandom_range(9))
                0: it.time_value = $urandom;
                1: it.time_value = 32'h0;
                default: it.time_value = $urandom_range(0, 196608);
            endcase
        end
        else if (r < 96)
        begin
            it = make_item(MODE_RENDER);
        end
        else
        begin
            it = make_item(2'd3);
        end
        return it;
    endfunction

    // Receiver: random stalls, or a long hold when one is requested.
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Compare each result beat with the oldest expectation.
    always @(posedge clk)
    begin
        particle_beat_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_beats.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual x=%h y=%h z=%h",
                         $time, out_x, out_y, out_z);
                fail_count++;
            end
            else
            begin
                e = pending_beats.pop_front();
                check_field("out_x", e.x, out_x);
                check_field("out_y", e.y, out_y);
                check_field("out_z", e.z, out_z);
                check_field("out_colour", e.colour, out_colour);
                check_field("life_fraction", 32'(e.frac), 32'(life_fraction));
                check_field("last", 32'(e.last), 32'(last));
                check_field("none_live", 32'(e.none_live), 32'(none_live));
            end
        end
    end

    // Watchdog on cycles with no handshake at all.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Empty pool, the unused mode and a zero lifetime.
    task automatic test_empty_pool();
        item_t it;
        send_item(make_item(MODE_RENDER));
        send_item(make_item(2'd3));
        it = make_item(MODE_EMIT);
        it.time_value = 32'h0;
        send_item(it);
        send_item(make_item(MODE_RENDER));
        drain_pool();
    endtask

    // Field extremes with the widest spreads, which are set to zero at the end.
    task automatic test_extremes();
        item_t it;
        write_all_spreads(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        it = make_item(MODE_EMIT);
        it.start = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0};
        it.speed = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        it.jitter = 48'hFFFF_FFFF_FFFF;
        it.time_value = 32'hFFFF_FFFF;
        it.hue_begin = 32'hFFFF_FFFF;
        it.hue_end = 32'h0;
        send_item(it);
        it.start = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
        it.speed = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        it.jitter = 48'h0;
        it.hue_begin = 32'h0;
        it.hue_end = 32'hFFFF_FFFF;
        send_item(it);
        it.speed = '{32'h0, 32'h0001_0000, 32'hFFFF_0000};
        it.jitter = 48'h8000_8000_8000;
        it.time_value = 32'h0000_0001;
        send_item(it);
        send_item(make_item(MODE_RENDER));
        it = make_item(MODE_TICK);
        it.time_value = 32'h7FFF_FFFF;
        send_item(it);
        send_item(make_item(MODE_RENDER));
        it.time_value = 32'h0;
        send_item(it);
        send_item(make_item(MODE_RENDER));
        it.time_value = 32'hFFFF_FFFF;
        send_item(it);
        send_item(make_item(MODE_RENDER));
        drain_pool();
        write_all_spreads(32'h0, 32'h0, 32'h0);
    endtask

    // Random traffic in three phases of input gaps and receiver stalls, each with new spreads.
    task automatic test_random_traffic();
        int gap_pct [3] = '{9, 49, 0};
        int stall_pct [3] = '{49, 9, 0};
        for (int ph = 0; ph < 3; ph++)
        begin
            in_gap_pct = gap_pct[ph];
            out_stall_pct = stall_pct[ph];
            write_all_spreads($urandom_range(0, 1 << 18), $urandom, 32'hFFFF_FFFF);
            for (int n = 0; n < RANDOM_ITEMS / 3; n++)
            begin
                send_item(random_item());
            end
            drain_pool();
        end
    endtask

    // Long receiver hold while items keep coming, then a full pause.
    task automatic test_backpressure();
        in_gap_pct = 0;
        out_stall_pct = 20;
        for (int n = 0; n < 20; n++)
        begin
            send_item(random_item());
        end
        hold_request = 1'b1;
        for (int n = 0; n < 6; n++)
        begin
            send_item(make_item(MODE_RENDER));
            send_item(random_item());
        end
        drain_pool();
        send_item(make_item(MODE_RENDER));
        drain_pool();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = MODE_EMIT;
        {start_x, start_y, start_z} = '0;
        {speed_x, speed_y, speed_z} = '0;
        time_value = '0;
        hue_begin = '0;
        hue_end = '0;
        jitter = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SPREAD_X;
        cfg_data = '0;
        fail_count = 0;
        quiet_cycles = 0;
        in_gap_pct = 0;
        out_stall_pct = 0;
        hold_request = 1'b0;
        hold_left = 0;
        emit_slot = POOL_SIZE - 1;
        spread = '{default: '0};
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_left[i] = 0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_pool();
        test_extremes();
        test_random_traffic();
        test_backpressure();

        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ppe_pkg.sv
rtl/ppe_ram.sv
rtl/ppe_mul.sv
rtl/particle_pool_engine.sv
test/testbench.sv
